@@ design/tsft_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsft_pkg
// shared codes and controller/datapath handshake types for the topic
// subscription fan-out table
// ----------------------------------------------------------------------------
package tsft_pkg;

  // request kinds
  localparam logic SUBSCRIBE = 1'b0;
  localparam logic PUBLISH   = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_TOPICS_FULL  = 2'd1;
  localparam logic [1:0] ST_MEMBERS_FULL = 2'd2;
  localparam logic [1:0] ST_EMPTY        = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic       start;       // latch request, clear scan pointers
    logic       key_scan;    // walk the topic key store
    logic       create;      // append the requested topic
    logic       cnt_rd;      // read member count of the selected topic
    logic       cnt_load;    // take member count, clear scan pointers
    logic       mem_scan;    // walk the member list of the selected topic
    logic       append;      // add the client to the member list
    logic       pub_rd;      // prefetch first member for fan-out
    logic       pub_emit;    // put one member into the output register
    logic       emit_status; // put a status-only item into the output register
    logic [1:0] status;      // status code for emit_status
  } tsft_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_pub;
    logic has_msg;
    logic no_topics;
    logic table_full;
    logic hit;
    logic miss_done;
    logic n_zero;
    logic list_full;
    logic pub_last;
    logic out_free;
  } tsft_sts_t;

endpackage

@@ design/tsft_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsft_datapath
// request registers, topic and member stores, scan pointers and the
// output register
// ----------------------------------------------------------------------------
module tsft_datapath import tsft_pkg::*; #(
  parameter int TOPIC_SLOTS       = 16,
  parameter int MEMBERS_PER_TOPIC = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_op_i,
  input  logic [63:0] req_key_i,
  input  logic [31:0] req_ip_i,
  input  logic [15:0] req_port_i,
  input  logic        req_msg_i,
  input  tsft_cmd_t   cmd_i,
  output tsft_sts_t   sts_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic        out_dest_valid_o,
  output logic [31:0] out_ip_o,
  output logic [15:0] out_port_o,
  output logic [1:0]  out_status_o,
  output logic        out_last_o
);

  localparam int TW = (TOPIC_SLOTS > 1) ? $clog2(TOPIC_SLOTS) : 1;
  localparam int CW = $clog2(TOPIC_SLOTS + 1);
  localparam int MW = (MEMBERS_PER_TOPIC > 1) ? $clog2(MEMBERS_PER_TOPIC) : 1;
  localparam int NW = $clog2(MEMBERS_PER_TOPIC + 1);
  localparam int IW = (CW > NW) ? CW : NW;

  // stores
  logic [63:0]   key_mem  [TOPIC_SLOTS];
  logic [NW-1:0] cnt_mem  [TOPIC_SLOTS];
  logic [31:0]   ip_mem   [TOPIC_SLOTS][MEMBERS_PER_TOPIC];
  logic [15:0]   port_mem [TOPIC_SLOTS][MEMBERS_PER_TOPIC];

  logic [63:0]   key_rd_q;
  logic [NW-1:0] cnt_rd_q;
  logic [31:0]   ip_rd_q;
  logic [15:0]   port_rd_q;

  // request
  logic          req_op_q;
  logic [63:0]   req_key_q;
  logic [31:0]   req_ip_q;
  logic [15:0]   req_port_q;
  logic          req_msg_q;

  // control state
  logic [CW-1:0] topics_used_q;
  logic [TW-1:0] topic_q;
  logic [NW-1:0] n_q;
  logic [IW-1:0] rd_idx_q;
  logic [IW-1:0] cmp_idx_q;
  logic          cmp_v_q;

  logic          out_valid_q;
  logic          out_dest_valid_q;
  logic [31:0]   out_ip_q;
  logic [15:0]   out_port_q;
  logic [1:0]    out_status_q;
  logic          out_last_q;

  logic [IW-1:0] bound;
  logic          scan_rd;
  logic          mem_rd;
  logic          match;
  logic          hit;
  logic          pub_last;
  logic          emit;

  assign bound    = cmd_i.key_scan ? IW'(topics_used_q) : IW'(n_q);
  assign scan_rd  = (cmd_i.key_scan || cmd_i.mem_scan) && (rd_idx_q < bound);
  assign pub_last = (rd_idx_q == IW'(n_q));
  assign mem_rd   = (cmd_i.mem_scan && scan_rd) || cmd_i.pub_rd ||
                    (cmd_i.pub_emit && !pub_last);
  assign match    = cmd_i.key_scan ? (key_rd_q == req_key_q)
                                   : ((ip_rd_q == req_ip_q) && (port_rd_q == req_port_q));
  assign hit      = cmp_v_q && match;
  assign emit     = cmd_i.pub_emit || cmd_i.emit_status;

  assign sts_o.is_pub     = (req_op_q == PUBLISH);
  assign sts_o.has_msg    = req_msg_q;
  assign sts_o.no_topics  = (topics_used_q == '0);
  assign sts_o.table_full = (topics_used_q == CW'(TOPIC_SLOTS));
  assign sts_o.hit        = hit;
  assign sts_o.miss_done  = cmp_v_q && !match && ((cmp_idx_q + IW'(1)) == bound);
  assign sts_o.n_zero     = (n_q == '0);
  assign sts_o.list_full  = (n_q == NW'(MEMBERS_PER_TOPIC));
  assign sts_o.pub_last   = pub_last;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      topics_used_q <= '0;
      topic_q       <= '0;
      n_q           <= '0;
      rd_idx_q      <= '0;
      cmp_idx_q     <= '0;
      cmp_v_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.start || cmd_i.cnt_load) begin
        rd_idx_q <= '0;
        cmp_v_q  <= 1'b0;
      end else if (cmd_i.key_scan || cmd_i.mem_scan) begin
        cmp_v_q   <= scan_rd;
        cmp_idx_q <= rd_idx_q;
        if (scan_rd) begin
          rd_idx_q <= rd_idx_q + IW'(1);
        end
      end else if (mem_rd) begin
        rd_idx_q <= rd_idx_q + IW'(1);
      end
      if (cmd_i.key_scan && hit) begin
        topic_q <= cmp_idx_q[TW-1:0];
      end
      if (cmd_i.create) begin
        topic_q       <= topics_used_q[TW-1:0];
        topics_used_q <= topics_used_q + CW'(1);
        n_q           <= '0;
      end
      if (cmd_i.cnt_load) begin
        n_q <= cnt_rd_q;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_op_q   <= req_op_i;
      req_key_q  <= req_key_i;
      req_ip_q   <= req_ip_i;
      req_port_q <= req_port_i;
      req_msg_q  <= req_msg_i;
    end
    if (cmd_i.emit_status) begin
      out_dest_valid_q <= 1'b0;
      out_ip_q         <= '0;
      out_port_q       <= '0;
      out_status_q     <= cmd_i.status;
      out_last_q       <= 1'b1;
    end else if (cmd_i.pub_emit) begin
      out_dest_valid_q <= 1'b1;
      out_ip_q         <= ip_rd_q;
      out_port_q       <= port_rd_q;
      out_status_q     <= ST_OK;
      out_last_q       <= pub_last;
    end
  end

  // topic key store and member counts
  always_ff @(posedge clk_i) begin
    if (cmd_i.create) begin
      key_mem[topics_used_q[TW-1:0]] <= req_key_q;
      cnt_mem[topics_used_q[TW-1:0]] <= '0;
    end else if (cmd_i.append) begin
      cnt_mem[topic_q] <= n_q + NW'(1);
    end
    if (cmd_i.key_scan && scan_rd) begin
      key_rd_q <= key_mem[rd_idx_q[TW-1:0]];
    end
    if (cmd_i.cnt_rd) begin
      cnt_rd_q <= cnt_mem[topic_q];
    end
  end

  // member store
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      ip_mem[topic_q][n_q[MW-1:0]]   <= req_ip_q;
      port_mem[topic_q][n_q[MW-1:0]] <= req_port_q;
    end
    if (mem_rd) begin
      ip_rd_q   <= ip_mem[topic_q][rd_idx_q[MW-1:0]];
      port_rd_q <= port_mem[topic_q][rd_idx_q[MW-1:0]];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_dest_valid_o = out_dest_valid_q;
  assign out_ip_o         = out_ip_q;
  assign out_port_o       = out_port_q;
  assign out_status_o     = out_status_q;
  assign out_last_o       = out_last_q;

endmodule

@@ design/tsft_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsft_controller
// request sequencer: topic lookup, membership update and fan-out
// ----------------------------------------------------------------------------
module tsft_controller import tsft_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tsft_sts_t sts_i,
  output tsft_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENTRY,
    S_KEY_SCAN,
    S_NEW,
    S_CNT_RD,
    S_CNT_LOAD,
    S_DECIDE,
    S_MEM_SCAN,
    S_APPEND,
    S_PUB_RD,
    S_PUB_EMIT,
    S_REPORT
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] st_q, st_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cmd_o   = '0;
    cmd_o.status = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_ENTRY;
        end
      end
      S_ENTRY: begin
        if (sts_i.is_pub && !sts_i.has_msg) begin
          st_d    = ST_EMPTY;
          state_d = S_REPORT;
        end else if (sts_i.no_topics) begin
          state_d = S_NEW;
        end else begin
          state_d = S_KEY_SCAN;
        end
      end
      S_KEY_SCAN: begin
        cmd_o.key_scan = 1'b1;
        if (sts_i.hit) begin
          state_d = S_CNT_RD;
        end else if (sts_i.miss_done) begin
          state_d = S_NEW;
        end
      end
      S_NEW: begin
        if (sts_i.table_full) begin
          st_d    = ST_TOPICS_FULL;
          state_d = S_REPORT;
        end else begin
          cmd_o.create = 1'b1;
          state_d      = S_DECIDE;
        end
      end
      S_CNT_RD: begin
        cmd_o.cnt_rd = 1'b1;
        state_d      = S_CNT_LOAD;
      end
      S_CNT_LOAD: begin
        cmd_o.cnt_load = 1'b1;
        state_d        = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.is_pub) begin
          if (sts_i.n_zero) begin
            st_d    = ST_OK;
            state_d = S_REPORT;
          end else begin
            state_d = S_PUB_RD;
          end
        end else if (sts_i.n_zero) begin
          state_d = S_APPEND;
        end else begin
          state_d = S_MEM_SCAN;
        end
      end
      S_MEM_SCAN: begin
        cmd_o.mem_scan = 1'b1;
        if (sts_i.hit) begin
          st_d    = ST_OK;
          state_d = S_REPORT;
        end else if (sts_i.miss_done) begin
          state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        if (sts_i.list_full) begin
          st_d = ST_MEMBERS_FULL;
        end else begin
          cmd_o.append = 1'b1;
          st_d         = ST_OK;
        end
        state_d = S_REPORT;
      end
      S_PUB_RD: begin
        cmd_o.pub_rd = 1'b1;
        state_d      = S_PUB_EMIT;
      end
      S_PUB_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.pub_emit = 1'b1;
          if (sts_i.pub_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_REPORT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

endmodule

@@ design/topic_subscription_fanout_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topic_subscription_fanout_table_unit
// publish/subscribe membership table with subscriber fan-out
// ----------------------------------------------------------------------------
// One request is handled at a time. A request passes through entry, a
// topic lookup over the topics in use (one key read per cycle from the
// key store), a fetch of the member count and the choice of path, then
// for subscribe a scan of the member list (one member read per cycle)
// and an update and report, and for publish one prefetch and then
// one subscriber per cycle for as long as the output is not stalled;
// a stalled output stretches it by the stall. A subscribe answers with one
// item (status ok, topic table full or list full); a publish with a message
// answers with one item per subscriber in subscription order, tlast on the
// final one, or a single status item if the topic has no subscribers or
// cannot be created; a publish with no message answers with one status
// item and leaves the table untouched. Results sit in an output register,
// so the next request is taken while the final result still waits.
// Stores come up undefined; no clearing pass is needed, the block is ready
// right after reset.
module topic_subscription_fanout_table_unit import tsft_pkg::*; #(
  parameter int TOPIC_SLOTS       = 16,
  parameter int MEMBERS_PER_TOPIC = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [111:0] s_axis_tdata_i,  // topic_key[63:0], client_ip[95:64],
                                        // client_port[111:96]
  input  logic [1:0]   s_axis_tuser_i,  // op[0], has_message[1]
  // result stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [47:0]  m_axis_tdata_o,  // dest_ip[31:0], dest_port[47:32]
  output logic [2:0]   m_axis_tuser_o,  // dest_valid[0], status[2:1]
  output logic         m_axis_tlast_o
);

  tsft_cmd_t   cmd;
  tsft_sts_t   sts;

  logic        out_dest_valid;
  logic [31:0] out_ip;
  logic [15:0] out_port;
  logic [1:0]  out_status;

  // sequencer: lookup, update and fan-out steps
  tsft_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stores, scan pointers and output register
  tsft_datapath #(
    .TOPIC_SLOTS       (TOPIC_SLOTS),
    .MEMBERS_PER_TOPIC (MEMBERS_PER_TOPIC)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_op_i         (s_axis_tuser_i[0]),
    .req_key_i        (s_axis_tdata_i[63:0]),
    .req_ip_i         (s_axis_tdata_i[95:64]),
    .req_port_i       (s_axis_tdata_i[111:96]),
    .req_msg_i        (s_axis_tuser_i[1]),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (m_axis_tready_i),
    .out_valid_o      (m_axis_tvalid_o),
    .out_dest_valid_o (out_dest_valid),
    .out_ip_o         (out_ip),
    .out_port_o       (out_port),
    .out_status_o     (out_status),
    .out_last_o       (m_axis_tlast_o)
  );

  // pack result fields, lowest field first
  assign m_axis_tdata_o = {out_port, out_ip};
  assign m_axis_tuser_o = {out_status, out_dest_valid};

endmodule
